FILE: sv/lobm_pkg.sv
package lobm_pkg;

    localparam int ORDER_W      = 10;
    localparam int MAX_ORDERS   = 1 << ORDER_W;
    localparam int PRICE_W      = 8;
    localparam int PRICE_LEVELS = 1 << PRICE_W;
    localparam int LEVEL_W      = PRICE_W + 1;
    localparam int NLEVELS      = 2 * PRICE_LEVELS;
    localparam int QTY_W        = 16;
    localparam int TIME_W       = 48;
    localparam int FILL_W       = 6;
    localparam int MAX_FILLS    = 63;
    localparam int TRADE_DEPTH  = 1 << FILL_W;
    localparam int GRP          = 16;
    localparam int GRP_W        = 4;
    localparam int NGRP         = PRICE_LEVELS / GRP;

    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_CANCEL  = 2'd1,
        OP_REPLACE = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_UNKNOWN   = 3'd1,
        ST_IN_USE    = 3'd2,
        ST_ZERO_QTY  = 3'd3,
        ST_TRUNCATED = 3'd4
    } t_status;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_TRADE  = 1'b1;

    typedef struct packed {
        logic [1:0]         op;
        logic [ORDER_W-1:0] order_id;
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   quantity;
        logic [TIME_W-1:0]  arrival_time;
    } t_req;

    typedef struct packed {
        logic               kind;
        logic [2:0]         status;
        logic [ORDER_W-1:0] buyer_id;
        logic [ORDER_W-1:0] seller_id;
        logic [PRICE_W-1:0] fill_price;
        logic [QTY_W-1:0]   fill_qty;
        logic [FILL_W-1:0]  fill_number;
        logic [PRICE_W-1:0] top_bid;
        logic               bid_valid;
        logic [PRICE_W-1:0] top_ask;
        logic               ask_valid;
        logic               last;
    } t_res;

    typedef struct packed {
        logic               side;
        logic [QTY_W-1:0]   qty;
        logic [PRICE_W-1:0] price;
    } t_terms;

    typedef struct packed {
        logic [ORDER_W-1:0] head;
        logic [ORDER_W-1:0] tail;
    } t_level;

    typedef struct packed {
        logic [ORDER_W-1:0] buyer;
        logic [ORDER_W-1:0] seller;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
    } t_trade;

endpackage

FILE: sv/lobm_ram.sv
module lobm_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: sv/limit_order_book_matcher_core.sv
// Price-time order book matcher. After reset the block clears all 1024 slots
// of its order liveness table, one slot a cycle, with busy high. A request
// is taken when start is high and busy low; busy then stays high until the
// closing status item is on the result ports, and a new request may be taken
// in that same cycle. Every table step is a read-modify-write on
// single-port-read RAMs; results follow as one unbroken burst of one trade
// per cycle and a closing status item, each shown for a single cycle with
// o_valid, which the receiver must take as it comes.
module limit_order_book_matcher_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  lobm_pkg::t_req  i_req,
    output logic            o_valid,
    output lobm_pkg::t_res  o_res
);
    import lobm_pkg::*;

    typedef enum logic [20:0] {
        S_CLR     = 21'd1 << 0,
        S_IDLE    = 21'd1 << 1,
        S_CHECK   = 21'd1 << 2,
        S_UNL_RD  = 21'd1 << 3,
        S_UNL_WR  = 21'd1 << 4,
        S_RPL_WR  = 21'd1 << 5,
        S_APP     = 21'd1 << 6,
        S_APP_WR  = 21'd1 << 7,
        S_F1      = 21'd1 << 8,
        S_F2      = 21'd1 << 9,
        S_CROSS   = 21'd1 << 10,
        S_H2      = 21'd1 << 11,
        S_H3      = 21'd1 << 12,
        S_T1      = 21'd1 << 13,
        S_T2      = 21'd1 << 14,
        S_T3      = 21'd1 << 15,
        S_US      = 21'd1 << 16,
        S_CAP     = 21'd1 << 17,
        S_END     = 21'd1 << 18,
        S_EMIT    = 21'd1 << 19,
        S_SPARE   = 21'd1 << 20
    } t_state;

    function automatic logic [GRP_W-1:0] f_hi(input logic [GRP-1:0] v);
        logic [GRP_W-1:0] r;
        r = '0;
        for (int i = 0; i < GRP; i++) begin
            if (v[i]) r = GRP_W'(i);
        end
        return r;
    endfunction

    function automatic logic [GRP_W-1:0] f_lo(input logic [GRP-1:0] v);
        logic [GRP_W-1:0] r;
        r = '0;
        for (int i = GRP - 1; i >= 0; i--) begin
            if (v[i]) r = GRP_W'(i);
        end
        return r;
    endfunction

    t_state r_state, n_state, r_ret, n_ret;
    logic [ORDER_W-1:0] r_clr, n_clr;
    logic [1:0]         r_op, n_op;
    logic [ORDER_W-1:0] r_id, n_id;
    logic               r_side, n_side;
    logic [PRICE_W-1:0] r_price, n_price;
    logic [QTY_W-1:0]   r_qty, n_qty;
    logic [TIME_W-1:0]  r_time, n_time;
    logic [2:0]         r_status, n_status;
    logic               r_done, n_done;
    logic [ORDER_W-1:0] r_uid, n_uid;
    logic [LEVEL_W-1:0] r_lv, n_lv;
    logic               r_kill, n_kill;
    logic [NLEVELS-1:0] r_occ, n_occ;
    logic [NGRP-1:0]    bid_any, ask_any;
    logic [GRP_W-1:0]   r_bgrp, n_bgrp, r_agrp, n_agrp;
    logic               r_bgv, n_bgv, r_agv, n_agv;
    logic [PRICE_W-1:0] r_bb, n_bb, r_ba, n_ba;
    logic               r_bv, n_bv, r_av, n_av;
    logic [ORDER_W-1:0] r_bid, n_bid, r_sid, n_sid;
    logic [QTY_W-1:0]   r_bq, n_bq, r_sq, n_sq;
    logic [PRICE_W-1:0] r_bp, n_bp, r_sp, n_sp;
    logic [TIME_W-1:0]  r_btime, n_btime;
    logic [FILL_W-1:0]  r_n, n_n, r_k, n_k;
    logic               r_valid, n_valid;
    t_res               r_res, n_res;
    t_terms             st;
    logic [QTY_W-1:0]   fq;
    logic               crossed;

    logic [ORDER_W-1:0] slot_raddr;
    logic [LEVEL_W-1:0] lvl_raddr;
    logic [FILL_W-1:0]  trd_raddr;
    logic               live_we, live_wd, live_rd;
    logic [ORDER_W-1:0] live_wa;
    logic               terms_we;
    logic [ORDER_W-1:0] terms_wa;
    t_terms             terms_wd, terms_rd;
    logic               time_we;
    logic [TIME_W-1:0]  time_rd;
    logic               next_we, prev_we;
    logic [ORDER_W-1:0] next_wa, next_wd, next_rd, prev_wa, prev_wd, prev_rd;
    logic               lvl_we;
    logic [LEVEL_W-1:0] lvl_wa;
    t_level             lvl_wd, lvl_rd;
    logic               trd_we;
    t_trade             trd_wd, trd_rd;

    lobm_ram #(.W(1), .D(MAX_ORDERS)) u_live (
        .i_clk(i_clk), .i_we(live_we), .i_waddr(live_wa), .i_wdata(live_wd),
        .i_raddr(slot_raddr), .o_rdata(live_rd)
    );
    lobm_ram #(.W($bits(t_terms)), .D(MAX_ORDERS)) u_terms (
        .i_clk(i_clk), .i_we(terms_we), .i_waddr(terms_wa), .i_wdata(terms_wd),
        .i_raddr(slot_raddr), .o_rdata(terms_rd)
    );
    lobm_ram #(.W(TIME_W), .D(MAX_ORDERS)) u_time (
        .i_clk(i_clk), .i_we(time_we), .i_waddr(r_id), .i_wdata(r_time),
        .i_raddr(slot_raddr), .o_rdata(time_rd)
    );
    lobm_ram #(.W(ORDER_W), .D(MAX_ORDERS)) u_next (
        .i_clk(i_clk), .i_we(next_we), .i_waddr(next_wa), .i_wdata(next_wd),
        .i_raddr(slot_raddr), .o_rdata(next_rd)
    );
    lobm_ram #(.W(ORDER_W), .D(MAX_ORDERS)) u_prev (
        .i_clk(i_clk), .i_we(prev_we), .i_waddr(prev_wa), .i_wdata(prev_wd),
        .i_raddr(slot_raddr), .o_rdata(prev_rd)
    );
    lobm_ram #(.W($bits(t_level)), .D(NLEVELS)) u_level (
        .i_clk(i_clk), .i_we(lvl_we), .i_waddr(lvl_wa), .i_wdata(lvl_wd),
        .i_raddr(lvl_raddr), .o_rdata(lvl_rd)
    );
    lobm_ram #(.W($bits(t_trade)), .D(TRADE_DEPTH)) u_trade (
        .i_clk(i_clk), .i_we(trd_we), .i_waddr(r_n), .i_wdata(trd_wd),
        .i_raddr(trd_raddr), .o_rdata(trd_rd)
    );

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            bid_any[g] = |r_occ[g*GRP +: GRP];
            ask_any[g] = |r_occ[PRICE_LEVELS + g*GRP +: GRP];
        end
    end

    assign crossed = r_bv && r_av && (r_bb >= r_ba);
    assign st      = terms_rd;
    assign fq      = (r_bq < st.qty) ? r_bq : st.qty;

    always_comb begin
        n_state = r_state;  n_ret = r_ret;   n_clr = r_clr;
        n_op = r_op;        n_id = r_id;     n_side = r_side;
        n_price = r_price;  n_qty = r_qty;   n_time = r_time;
        n_status = r_status; n_done = r_done; n_uid = r_uid;
        n_lv = r_lv;        n_kill = r_kill; n_occ = r_occ;
        n_bgrp = r_bgrp;    n_agrp = r_agrp; n_bgv = r_bgv; n_agv = r_agv;
        n_bb = r_bb;        n_ba = r_ba;     n_bv = r_bv;   n_av = r_av;
        n_bid = r_bid;      n_sid = r_sid;   n_bq = r_bq;   n_sq = r_sq;
        n_bp = r_bp;        n_sp = r_sp;     n_btime = r_btime;
        n_n = r_n;          n_k = r_k;
        n_valid = 1'b0;     n_res = r_res;

        slot_raddr = r_uid;
        lvl_raddr  = r_lv;
        trd_raddr  = '0;
        live_we = 1'b0;  live_wa = r_uid;  live_wd = 1'b0;
        terms_we = 1'b0; terms_wa = r_id;  terms_wd = t_terms'({r_side, r_qty, r_price});
        time_we = 1'b0;
        next_we = 1'b0;  next_wa = lvl_rd.tail; next_wd = r_uid;
        prev_we = 1'b0;  prev_wa = r_uid;       prev_wd = lvl_rd.tail;
        lvl_we = 1'b0;   lvl_wa = r_lv;         lvl_wd = t_level'({r_uid, r_uid});
        trd_we = 1'b0;
        trd_wd = t_trade'({r_bid, r_sid,
                           (r_btime < time_rd) ? r_bp : st.price, fq});

        unique case (r_state)
            S_CLR: begin
                live_we = 1'b1;
                live_wa = r_clr;
                n_clr   = r_clr + 1'b1;
                if (&r_clr) n_state = S_IDLE;
            end
            S_IDLE: begin
                slot_raddr = i_req.order_id;
                if (start) begin
                    n_op = i_req.op;       n_id = i_req.order_id;
                    n_side = i_req.side;   n_price = i_req.price;
                    n_qty = i_req.quantity; n_time = i_req.arrival_time;
                    n_uid = i_req.order_id;
                    n_status = ST_OK;  n_done = 1'b0;
                    n_n = '0;          n_k = '0;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (r_op == OP_NOP) begin
                    n_done = 1'b1;
                    n_state = S_F1;
                end else if (r_op == OP_ADD) begin
                    if (live_rd) begin
                        n_status = ST_IN_USE;  n_done = 1'b1;  n_state = S_F1;
                    end else if (r_qty == '0) begin
                        n_status = ST_ZERO_QTY; n_done = 1'b1; n_state = S_F1;
                    end else begin
                        terms_we = 1'b1;
                        time_we  = 1'b1;
                        live_we  = 1'b1;
                        live_wa  = r_id;
                        live_wd  = 1'b1;
                        n_lv     = {r_side, r_price};
                        n_state  = S_APP;
                    end
                end else if (!live_rd) begin
                    n_status = ST_UNKNOWN;  n_done = 1'b1;  n_state = S_F1;
                end else if (r_op == OP_CANCEL) begin
                    n_lv = {terms_rd.side, terms_rd.price};
                    n_kill = 1'b1;  n_done = 1'b1;
                    n_ret = S_F1;   n_state = S_UNL_RD;
                end else if (r_qty == '0) begin
                    n_status = ST_ZERO_QTY; n_done = 1'b1; n_state = S_F1;
                end else begin
                    n_side = terms_rd.side;
                    n_lv = {terms_rd.side, terms_rd.price};
                    n_kill = 1'b0;
                    n_ret = S_RPL_WR;  n_state = S_UNL_RD;
                end
            end
            S_UNL_RD: begin
                n_state = S_UNL_WR;
            end
            S_UNL_WR: begin
                live_we = r_kill;
                priority if (lvl_rd.head == r_uid && lvl_rd.tail == r_uid) begin
                    n_occ[r_lv] = 1'b0;
                end else if (lvl_rd.head == r_uid) begin
                    lvl_we = 1'b1;
                    lvl_wd = t_level'({next_rd, lvl_rd.tail});
                end else if (lvl_rd.tail == r_uid) begin
                    lvl_we = 1'b1;
                    lvl_wd = t_level'({lvl_rd.head, prev_rd});
                end else begin
                    next_we = 1'b1;  next_wa = prev_rd;  next_wd = next_rd;
                    prev_we = 1'b1;  prev_wa = next_rd;  prev_wd = prev_rd;
                end
                n_state = r_ret;
            end
            S_RPL_WR: begin
                terms_we = 1'b1;
                n_lv = {r_side, r_price};
                n_state = S_APP;
            end
            S_APP: begin
                if (!r_occ[r_lv]) begin
                    lvl_we = 1'b1;
                    n_occ[r_lv] = 1'b1;
                    n_state = S_F1;
                end else begin
                    n_state = S_APP_WR;
                end
            end
            S_APP_WR: begin
                next_we = 1'b1;
                prev_we = 1'b1;
                lvl_we  = 1'b1;
                lvl_wd  = t_level'({lvl_rd.head, r_uid});
                n_state = S_F1;
            end
            S_F1: begin
                n_bgv = |bid_any;  n_bgrp = f_hi(bid_any);
                n_agv = |ask_any;  n_agrp = f_lo(ask_any);
                n_state = S_F2;
            end
            S_F2: begin
                n_bv = r_bgv;
                n_av = r_agv;
                n_bb = r_bgv ? {r_bgrp, f_hi(r_occ[r_bgrp*GRP +: GRP])} : '0;
                n_ba = r_agv ? {r_agrp, f_lo(r_occ[PRICE_LEVELS + r_agrp*GRP +: GRP])} : '0;
                n_state = S_CROSS;
            end
            S_CROSS: begin
                slot_raddr = r_id;
                lvl_raddr  = {SIDE_BUY, r_bb};
                priority if (r_done || !crossed) begin
                    n_state = S_END;
                end else if (r_n == FILL_W'(MAX_FILLS)) begin
                    n_state = S_CAP;
                end else begin
                    n_state = S_H2;
                end
            end
            S_CAP: begin
                n_done = 1'b1;
                if (live_rd) begin
                    n_uid = r_id;
                    n_lv = {terms_rd.side, terms_rd.price};
                    n_kill = 1'b1;
                    n_status = ST_TRUNCATED;
                    n_ret = S_F1;
                    n_state = S_UNL_RD;
                end else begin
                    n_state = S_END;
                end
            end
            S_H2: begin
                lvl_raddr = {SIDE_SELL, r_ba};
                n_bid = lvl_rd.head;
                n_state = S_H3;
            end
            S_H3: begin
                slot_raddr = r_bid;
                n_sid = lvl_rd.head;
                n_state = S_T1;
            end
            S_T1: begin
                slot_raddr = r_sid;
                n_bq = terms_rd.qty;
                n_bp = terms_rd.price;
                n_btime = time_rd;
                n_state = S_T2;
            end
            S_T2: begin
                trd_we = 1'b1;
                n_bq = r_bq - fq;
                n_sq = st.qty - fq;
                n_sp = st.price;
                terms_we = (r_bq != fq);
                terms_wa = r_bid;
                terms_wd = t_terms'({SIDE_BUY, r_bq - fq, r_bp});
                n_n = r_n + 1'b1;
                n_state = S_T3;
            end
            S_T3: begin
                terms_we = (r_sq != '0);
                terms_wa = r_sid;
                terms_wd = t_terms'({SIDE_SELL, r_sq, r_sp});
                if (r_bq == '0) begin
                    n_uid = r_bid;  n_lv = {SIDE_BUY, r_bp};
                    n_kill = 1'b1;  n_ret = S_US;  n_state = S_UNL_RD;
                end else begin
                    n_state = S_US;
                end
            end
            S_US: begin
                if (r_sq == '0) begin
                    n_uid = r_sid;  n_lv = {SIDE_SELL, r_sp};
                    n_kill = 1'b1;  n_ret = S_F1;  n_state = S_UNL_RD;
                end else begin
                    n_state = S_F1;
                end
            end
            S_END: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                trd_raddr = r_k + 1'b1;
                n_valid = 1'b1;
                n_res.top_bid = r_bb;  n_res.bid_valid = r_bv;
                n_res.top_ask = r_ba;  n_res.ask_valid = r_av;
                if (r_k != r_n) begin
                    n_res.kind = KIND_TRADE;
                    n_res.status = ST_OK;
                    n_res.buyer_id = trd_rd.buyer;
                    n_res.seller_id = trd_rd.seller;
                    n_res.fill_price = trd_rd.price;
                    n_res.fill_qty = trd_rd.qty;
                    n_res.fill_number = r_k + 1'b1;
                    n_res.last = 1'b0;
                    n_k = r_k + 1'b1;
                end else begin
                    n_res.kind = KIND_STATUS;
                    n_res.status = r_status;
                    n_res.buyer_id = '0;
                    n_res.seller_id = '0;
                    n_res.fill_price = '0;
                    n_res.fill_qty = '0;
                    n_res.fill_number = '0;
                    n_res.last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ret   <= S_F1;
            r_clr   <= '0;
            r_occ   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_clr   <= n_clr;
            r_occ   <= n_occ;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;         r_id <= n_id;       r_side <= n_side;
        r_price <= n_price;   r_qty <= n_qty;     r_time <= n_time;
        r_status <= n_status; r_done <= n_done;   r_uid <= n_uid;
        r_lv <= n_lv;         r_kill <= n_kill;
        r_bgrp <= n_bgrp;     r_agrp <= n_agrp;   r_bgv <= n_bgv;  r_agv <= n_agv;
        r_bb <= n_bb;         r_ba <= n_ba;       r_bv <= n_bv;    r_av <= n_av;
        r_bid <= n_bid;       r_sid <= n_sid;     r_bq <= n_bq;    r_sq <= n_sq;
        r_bp <= n_bp;         r_sp <= n_sp;       r_btime <= n_btime;
        r_n <= n_n;           r_k <= n_k;         r_res <= n_res;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule

FILE: sv/lobm_checker.sv
module lobm_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_valid,
    input lobm_pkg::t_res o_res
);
    import lobm_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request taken without going busy");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.last |=> !o_valid)
        else $error("result after closing status");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.kind == KIND_STATUS |-> o_res.last)
        else $error("status item not last");

    a_bid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_res.bid_valid |-> o_res.top_bid == '0)
        else $error("top bid without bid");

    a_fill_qty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.kind == KIND_TRADE |-> o_res.fill_qty != '0)
        else $error("empty trade");
endmodule

bind limit_order_book_matcher_core lobm_checker u_lobm_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_res(o_res)
);

FILE: tb/sv/tb.sv
module tb;
    import lobm_pkg::*;

    localparam int NUM_PRICES = PRICE_LEVELS;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    t_req   i_req = '0;
    logic   o_valid;
    t_res   o_res;

    int     mismatch_count = 0;
    int     sender_idle_pct = 0;

    always #5 i_clk = ~i_clk;

    limit_order_book_matcher_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    class book_scoreboard;
        bit             live[MAX_ORDERS];
        t_terms         terms[MAX_ORDERS];
        logic [47:0]    stamp[MAX_ORDERS];
        int             nxt[MAX_ORDERS];
        int             prv[MAX_ORDERS];
        int             head[NLEVELS];
        int             tail[NLEVELS];
        bit             occ[NLEVELS];
        t_res           pending_results[$];

        function int level_index(int id);
            return terms[id].side * NUM_PRICES + terms[id].price;
        endfunction

        function void append_order(int id);
            int lv;
            lv = level_index(id);
            if (!occ[lv]) begin
                head[lv] = id;
                tail[lv] = id;
                occ[lv] = 1;
            end else begin
                nxt[tail[lv]] = id;
                prv[id] = tail[lv];
                tail[lv] = id;
            end
        endfunction

        function void unlink_order(int id);
            int lv;
            lv = level_index(id);
            if (head[lv] == id && tail[lv] == id) begin
                occ[lv] = 0;
            end else if (head[lv] == id) begin
                head[lv] = nxt[id];
            end else if (tail[lv] == id) begin
                tail[lv] = prv[id];
            end else begin
                nxt[prv[id]] = nxt[id];
                prv[nxt[id]] = prv[id];
            end
        endfunction

        function bit best_bid(output int p);
            p = 0;
            for (int i = NUM_PRICES - 1; i >= 0; i--) begin
                if (occ[i]) begin
                    p = i;
                    return 1;
                end
            end
            return 0;
        endfunction

        function bit best_ask(output int p);
            p = 0;
            for (int i = 0; i < NUM_PRICES; i++) begin
                if (occ[NUM_PRICES + i]) begin
                    p = i;
                    return 1;
                end
            end
            return 0;
        endfunction

        function bit book_crossed();
            int b, a;
            bit bv, av;
            bv = best_bid(b);
            av = best_ask(a);
            return bv && av && b >= a;
        endfunction

        function void note_request(t_req r);
            int id, b, a, bid, sid, fills;
            logic [15:0] bq, sq, fq;
            bit do_match, bv, av;
            t_status st;
            t_res res;
            t_res run[$];
            id = int'(r.order_id);
            do_match = 0;
            st = ST_OK;
            fills = 0;
            if (t_op'(r.op) == OP_ADD) begin
                if (live[id]) begin
                    st = ST_IN_USE;
                end else if (r.quantity == 0) begin
                    st = ST_ZERO_QTY;
                end else begin
                    terms[id] = '{side: r.side, qty: r.quantity, price: r.price};
                    stamp[id] = r.arrival_time;
                    live[id] = 1;
                    append_order(id);
                    do_match = 1;
                end
            end else if (t_op'(r.op) == OP_CANCEL) begin
                if (!live[id]) begin
                    st = ST_UNKNOWN;
                end else begin
                    unlink_order(id);
                    live[id] = 0;
                end
            end else if (t_op'(r.op) == OP_REPLACE) begin
                if (!live[id]) begin
                    st = ST_UNKNOWN;
                end else if (r.quantity == 0) begin
                    st = ST_ZERO_QTY;
                end else begin
                    unlink_order(id);
                    terms[id].qty = r.quantity;
                    terms[id].price = r.price;
                    append_order(id);
                    do_match = 1;
                end
            end
            if (do_match) begin
                while (fills < MAX_FILLS && book_crossed()) begin
                    void'(best_bid(b));
                    void'(best_ask(a));
                    bid = head[b];
                    sid = head[NUM_PRICES + a];
                    bq = terms[bid].qty;
                    sq = terms[sid].qty;
                    fq = (bq < sq) ? bq : sq;
                    res = '0;
                    res.kind = KIND_TRADE;
                    res.buyer_id = ORDER_W'(bid);
                    res.seller_id = ORDER_W'(sid);
                    res.fill_price = (stamp[bid] < stamp[sid]) ? terms[bid].price
                                                               : terms[sid].price;
                    res.fill_qty = fq;
                    res.fill_number = FILL_W'(fills + 1);
                    run.push_back(res);
                    bq -= fq;
                    sq -= fq;
                    if (bq == 0) begin
                        unlink_order(bid);
                        live[bid] = 0;
                    end else begin
                        terms[bid].qty = bq;
                    end
                    if (sq == 0) begin
                        unlink_order(sid);
                        live[sid] = 0;
                    end else begin
                        terms[sid].qty = sq;
                    end
                    fills++;
                end
                if (book_crossed() && live[id]) begin
                    unlink_order(id);
                    live[id] = 0;
                    st = ST_TRUNCATED;
                end
            end
            res = '0;
            res.kind = KIND_STATUS;
            res.status = st;
            res.last = 1;
            run.push_back(res);
            bv = best_bid(b);
            av = best_ask(a);
            foreach (run[k]) begin
                run[k].top_bid = PRICE_W'(b);
                run[k].bid_valid = bv;
                run[k].top_ask = PRICE_W'(a);
                run[k].ask_valid = av;
                pending_results.push_back(run[k]);
            end
        endfunction

        task check_result(t_res got);
            t_res want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
                return;
            end
            want = pending_results.pop_front();
            if (got.kind != want.kind) report_mismatch("kind");
            if (got.status != want.status)
                report_mismatch($sformatf("status %0d want %0d", got.status, want.status));
            if (got.buyer_id != want.buyer_id) report_mismatch("buyer_id");
            if (got.seller_id != want.seller_id) report_mismatch("seller_id");
            if (got.fill_price != want.fill_price) report_mismatch("fill_price");
            if (got.fill_qty != want.fill_qty) report_mismatch("fill_qty");
            if (got.fill_number != want.fill_number) report_mismatch("fill_number");
            if (got.top_bid != want.top_bid) report_mismatch("top_bid");
            if (got.bid_valid != want.bid_valid) report_mismatch("bid_valid");
            if (got.top_ask != want.top_ask) report_mismatch("top_ask");
            if (got.ask_valid != want.ask_valid) report_mismatch("ask_valid");
            if (got.last != want.last) report_mismatch("last");
        endtask
    endclass

    book_scoreboard book = new();

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) book.check_result(o_res);
    end

    task automatic send_request(input t_req r);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        book.note_request(r);
    endtask

    task automatic send_order(input t_op op, input int id, input bit sd, input int pr,
                              input int qty, input logic [47:0] ts);
        t_req r;
        r.op = op;
        r.order_id = ORDER_W'(id);
        r.side = sd;
        r.price = PRICE_W'(pr);
        r.quantity = QTY_W'(qty);
        r.arrival_time = ts;
        send_request(r);
    endtask

    function automatic int pick_id(input bit want_live);
        int id;
        for (int tries = 0; tries < 50; tries++) begin
            id = $urandom_range(63);
            if (book.live[id] == want_live) return id;
        end
        return id;
    endfunction

    task automatic random_request(input logic [47:0] ts);
        t_req r;
        int sel;
        logic [95:0] raw;
        r = '0;
        r.arrival_time = ts;
        r.price = PRICE_W'(90 + $urandom_range(20));
        r.quantity = QTY_W'($urandom_range(1, 300));
        r.side = 1'($urandom_range(1));
        sel = $urandom_range(99);
        if (sel < 60) begin
            r.op = OP_ADD;
            r.order_id = ORDER_W'(pick_id(0));
        end else if (sel < 75) begin
            r.op = OP_CANCEL;
            r.order_id = ORDER_W'(pick_id(1));
        end else if (sel < 88) begin
            r.op = OP_REPLACE;
            r.order_id = ORDER_W'(pick_id(1));
        end else begin
            raw = {$urandom, $urandom, $urandom};
            r = raw[$bits(t_req)-1:0];
            if (!book.live[r.order_id] && r.op == OP_REPLACE && r.quantity != 0)
                r.op = OP_CANCEL;
        end
        send_request(r);
    endtask

    task automatic wait_drain();
        while (book.pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        logic [47:0] ts;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        sender_idle_pct = 14;
        send_order(OP_CANCEL, 0, 0, 0, 0, 0);
        send_order(OP_REPLACE, 1023, 0, 5, 5, 0);
        send_order(OP_ADD, 1023, 1, 255, 65535, 48'hFFFF_FFFF_FFFF);
        send_order(OP_ADD, 1023, 0, 1, 1, 0);
        send_order(OP_ADD, 5, 0, 0, 0, 1);
        send_order(OP_ADD, 6, 0, 0, 10, 1);
        send_order(OP_ADD, 7, 0, 254, 30, 5);
        send_order(OP_NOP, 8, 1, 3, 3, 3);
        send_order(OP_ADD, 9, 1, 200, 10, 5);
        send_order(OP_ADD, 10, 1, 254, 100, 2);
        send_order(OP_REPLACE, 1023, 0, 200, 0, 0);
        send_order(OP_REPLACE, 1023, 0, 250, 65535, 0);
        send_order(OP_CANCEL, 6, 0, 0, 0, 0);
        send_order(OP_CANCEL, 6, 0, 0, 0, 0);
        send_order(OP_CANCEL, 10, 0, 0, 0, 0);
        send_order(OP_CANCEL, 1023, 0, 0, 0, 0);
        for (int i = 0; i < 70; i++) send_order(OP_ADD, 100 + i, 1, 50, 1, i);
        send_order(OP_ADD, 200, 0, 60, 200, 1000);
        for (int i = 0; i < 70; i++) send_order(OP_CANCEL, 100 + i, 0, 0, 0, 0);
        send_order(OP_CANCEL, 200, 0, 0, 0, 0);
        ts = 48'd2000;
        for (int n = 0; n < 320; n++) begin
            if (n == 107) sender_idle_pct = 71;
            if (n == 214) sender_idle_pct = 0;
            ts += $urandom_range(3);
            random_request(ts);
        end
        start <= 1'b0;
        wait_drain();
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule

FILE: files.f
sv/lobm_pkg.sv
sv/lobm_ram.sv
sv/limit_order_book_matcher_core.sv
sv/lobm_checker.sv
tb/sv/tb.sv
